FILE: design/ppmfd_pkg.sv
package ppmfd_pkg;

   localparam int NUM_CHANNELS  = 9;
   localparam int CTRL_CHANNELS = 4;
   localparam int CH_ADDR_W     = $clog2(NUM_CHANNELS);
   localparam int IDX_W         = $clog2(NUM_CHANNELS + 1);

   localparam int TIME_W     = 16;
   localparam int INTERVAL_W = 17;
   localparam int SLOT_W     = 5;
   localparam int RDCH_W     = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [TIME_W-1:0] RST_SYNC_THRESHOLD = 16'd6000;
   localparam logic [TIME_W-1:0] RST_MIN_WIDTH      = 16'd1600;
   localparam logic [TIME_W-1:0] RST_MAX_WIDTH      = 16'd4400;
   localparam logic [TIME_W-1:0] DEFAULT_LOW_WIDTH  = 16'd1600;
   localparam logic [TIME_W-1:0] DEFAULT_MID_WIDTH  = 16'd3000;

   typedef enum logic [1:0] {
      KIND_EDGE  = 2'd0,
      KIND_CHECK = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_THRESHOLD = 2'd0,
      CSR_MIN_WIDTH      = 2'd1,
      CSR_MAX_WIDTH      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TIME_W-1:0] edge_time;
      logic [RDCH_W-1:0] read_channel;
   } req_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0]    interval;
      logic [SLOT_W-1:0]        slot;
      logic                     is_sync;
      logic                     stored;
      logic [CTRL_CHANNELS-1:0] missing_mask;
      logic                     failsafe;
      logic [TIME_W-1:0]        channel_value;
   } rsp_type;

   typedef struct packed {
      logic                 en;
      logic [CH_ADDR_W-1:0] addr;
      logic [TIME_W-1:0]    data;
   } chan_wr_type;

   function automatic logic [TIME_W-1:0] chan_default(input logic [CH_ADDR_W-1:0] ch);
      logic [TIME_W-1:0] w;
      w = DEFAULT_LOW_WIDTH;
      if (ch >= CH_ADDR_W'(1) && ch <= CH_ADDR_W'(3)) begin
         w = DEFAULT_MID_WIDTH;
      end
      return w;
   endfunction

endpackage

FILE: design/ppmfd_chan_mem.sv
module ppmfd_chan_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  ppmfd_pkg::chan_wr_type        wr,
   input  logic                          rd_en,
   input  logic [ppmfd_pkg::CH_ADDR_W-1:0] rd_addr,
   output logic [ppmfd_pkg::TIME_W-1:0]  rd_data
);
   import ppmfd_pkg::*;

   logic [TIME_W-1:0]       mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;
   logic [NUM_CHANNELS-1:0] valid_in;
   logic [TIME_W-1:0]       rdata_ff;
   logic [TIME_W-1:0]       rdef_ff;
   logic                    rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
         rdef_ff   <= chan_default(rd_addr);
      end
   end

   // entry never written since reset reads as its default width
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : rdef_ff;

endmodule

FILE: design/ppmfd_frame.sv
module ppmfd_frame (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [ppmfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ppmfd_pkg::TIME_W-1:0]      csr_wdata,
   input  logic                              fire,
   input  ppmfd_pkg::req_type                req,
   output ppmfd_pkg::rsp_type                res,
   output ppmfd_pkg::chan_wr_type            wr
);
   import ppmfd_pkg::*;

   logic [TIME_W-1:0]        sync_thr_ff;
   logic [TIME_W-1:0]        min_w_ff;
   logic [TIME_W-1:0]        max_w_ff;
   logic [TIME_W-1:0]        last_edge_ff, last_edge_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [CTRL_CHANNELS-1:0] upd_ff, upd_in;
   logic                     failsafe_ff, failsafe_in;

   logic [INTERVAL_W-1:0]    interval;
   logic                     is_sync;
   logic                     in_window;
   logic                     idx_open;
   logic                     do_store;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_thr_ff <= RST_SYNC_THRESHOLD;
         min_w_ff    <= RST_MIN_WIDTH;
         max_w_ff    <= RST_MAX_WIDTH;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SYNC_THRESHOLD: sync_thr_ff <= csr_wdata;
            CSR_MIN_WIDTH:      min_w_ff    <= csr_wdata;
            CSR_MAX_WIDTH:      max_w_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // equal stamps wrap to a full timer period
   assign interval  = {req.edge_time == last_edge_ff, req.edge_time - last_edge_ff};
   assign is_sync   = interval > {1'b0, sync_thr_ff};
   assign in_window = interval >= {1'b0, min_w_ff} && interval <= {1'b0, max_w_ff};
   assign idx_open  = idx_ff < IDX_W'(NUM_CHANNELS);
   assign do_store  = req.kind == KIND_EDGE && !is_sync && idx_open && in_window;

   assign wr.en   = fire && do_store;
   assign wr.addr = idx_ff[CH_ADDR_W-1:0];
   assign wr.data = interval[TIME_W-1:0];

   always_comb begin
      last_edge_in = last_edge_ff;
      idx_in       = idx_ff;
      upd_in       = upd_ff;
      failsafe_in  = failsafe_ff;
      res          = '0;
      case (req.kind)
         KIND_EDGE: begin
            res.interval = interval;
            res.slot     = SLOT_W'(idx_ff);
            res.is_sync  = is_sync;
            res.stored   = do_store;
            last_edge_in = req.edge_time;
            if (is_sync) begin
               idx_in = '0;
            end else if (idx_open) begin
               idx_in = idx_ff + IDX_W'(1);
            end
            // only the control channels' updated flags are ever examined
            if (do_store && idx_ff < IDX_W'(CTRL_CHANNELS)) begin
               upd_in[idx_ff[$clog2(CTRL_CHANNELS)-1:0]] = 1'b1;
            end
         end
         KIND_CHECK: begin
            res.missing_mask = ~upd_ff;
            failsafe_in      = failsafe_ff | ~&upd_ff;
            upd_in           = '0;
         end
         default: ;
      endcase
      res.failsafe = failsafe_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         idx_ff       <= '0;
         upd_ff       <= '0;
         failsafe_ff  <= 1'b0;
      end else if (fire) begin
         last_edge_ff <= last_edge_in;
         idx_ff       <= idx_in;
         upd_ff       <= upd_in;
         failsafe_ff  <= failsafe_in;
      end
   end

endmodule

FILE: design/ppm_frame_decoder_failsafe_top.sv
// PPM frame decoder with failsafe. Each request transaction is a rising-edge
// timestamp (kind 0), a failsafe check of control channels 0..3 (kind 1) or a
// channel read (kind 2); each yields exactly one response transaction. A new
// request is taken every cycle unless req_stall is high: edge and check items
// update the frame state in the cycle they are accepted, while a read fetches
// the channel width memory through its registered read port. Channel widths
// start at their default values after reset with no clearing pass. csr writes
// to sync_threshold, min_width and max_width must be made while the block is
// idle; index 3 is ignored.
module ppm_frame_decoder_failsafe_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ppmfd_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ppmfd_pkg::rsp_type                rsp_data,
   input  logic                              csr_write_en,
   input  logic [ppmfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ppmfd_pkg::TIME_W-1:0]      csr_wdata
);
   import ppmfd_pkg::*;

   logic                  req_fire;
   logic                  rd_in_range;
   logic                  rd_en;
   rsp_type               res;
   chan_wr_type           wr;
   logic [TIME_W-1:0]     mem_rd_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               res_ff;
   logic                  rd_sel_ff;

   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign req_fire    = req_valid && !req_stall;
   assign rd_in_range = {1'b0, req_data.read_channel} < (RDCH_W + 1)'(NUM_CHANNELS);
   assign rd_en       = req_fire && req_data.kind == KIND_READ && rd_in_range;

   ppmfd_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fire         (req_fire),
      .req          (req_data),
      .res          (res),
      .wr           (wr)
   );

   ppmfd_chan_mem u_chan_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (req_data.read_channel[CH_ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         res_ff    <= res;
         rd_sel_ff <= rd_en;
      end
   end

   always_comb begin
      rsp_data               = res_ff;
      rsp_data.channel_value = rd_sel_ff ? mem_rd_data : '0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sim/ppmfd_checker.sv
`timescale 1ns / 1ps

module ppmfd_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  ppmfd_pkg::req_type   req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ppmfd_pkg::rsp_type   rsp_data,
   input  logic                 csr_write_en,
   input  logic [ppmfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ppmfd_pkg::TIME_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   checked_count,
   output int                   pending_count
);

   import ppmfd_pkg::*;

   localparam int                    PRINT_LIMIT = 30;
   localparam logic [INTERVAL_W-1:0] TIMER_SPAN  = 17'h10000;

   // shadow copy of the decoder state and its registers
   logic [TIME_W-1:0] sync_threshold;
   logic [TIME_W-1:0] min_width;
   logic [TIME_W-1:0] max_width;
   logic [TIME_W-1:0] last_edge;
   int                chan_idx;
   logic [TIME_W-1:0] chan_width [NUM_CHANNELS];
   logic              chan_updated [NUM_CHANNELS];
   logic              failsafe_q;

   rsp_type expected_rsp_q[$];
   rsp_type want;

   initial begin
      fail_count    = 0;
      checked_count = 0;
      pending_count = 0;
   end

   function automatic rsp_type decode_transaction(input req_type rq);
      rsp_type               r;
      logic [INTERVAL_W-1:0] span;
      int                    j;
      r = '0;
      case (rq.kind)
         KIND_EDGE: begin
            if (rq.edge_time > last_edge) begin
               span = {1'b0, rq.edge_time} - {1'b0, last_edge};
            end else begin
               // equal stamps land here and count as a full timer span
               span = TIMER_SPAN + {1'b0, rq.edge_time} - {1'b0, last_edge};
            end
            r.interval = span;
            r.slot     = SLOT_W'(chan_idx);
            if (span > {1'b0, sync_threshold}) begin
               r.is_sync = 1'b1;
               chan_idx  = 0;
            end else if (chan_idx < NUM_CHANNELS) begin
               if (span >= {1'b0, min_width} && span <= {1'b0, max_width}) begin
                  chan_width[chan_idx]   = span[TIME_W-1:0];
                  chan_updated[chan_idx] = 1'b1;
                  r.stored               = 1'b1;
               end
               chan_idx++;
            end
            last_edge = rq.edge_time;
         end
         KIND_CHECK: begin
            for (j = 0; j < CTRL_CHANNELS; j++) begin
               if (!chan_updated[j]) begin
                  r.missing_mask[j] = 1'b1;
                  failsafe_q        = 1'b1;
               end else begin
                  chan_updated[j] = 1'b0;
               end
            end
         end
         KIND_READ: begin
            if (rq.read_channel < NUM_CHANNELS) begin
               r.channel_value = chan_width[rq.read_channel];
            end
         end
         default: begin
         end
      endcase
      r.failsafe = failsafe_q;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                  input logic [63:0] got_val);
      if (fail_count < PRINT_LIMIT) begin
         $display("mismatch at response %0d: %s expected %0h got %0h",
                  checked_count, what, exp_val, got_val);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sync_threshold = RST_SYNC_THRESHOLD;
         min_width      = RST_MIN_WIDTH;
         max_width      = RST_MAX_WIDTH;
         last_edge      = '0;
         chan_idx       = 0;
         failsafe_q     = 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_width[i]   = (i >= 1 && i <= 3) ? DEFAULT_MID_WIDTH : DEFAULT_LOW_WIDTH;
            chan_updated[i] = 1'b0;
         end
         expected_rsp_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_SYNC_THRESHOLD: sync_threshold = csr_wdata;
               CSR_MIN_WIDTH:      min_width      = csr_wdata;
               CSR_MAX_WIDTH:      max_width      = csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(decode_transaction(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("transaction with none expected", '0, rsp_data);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.interval !== want.interval)
                  report_mismatch("interval", want.interval, rsp_data.interval);
               if (rsp_data.slot !== want.slot)
                  report_mismatch("slot", want.slot, rsp_data.slot);
               if (rsp_data.is_sync !== want.is_sync)
                  report_mismatch("is_sync", want.is_sync, rsp_data.is_sync);
               if (rsp_data.stored !== want.stored)
                  report_mismatch("stored", want.stored, rsp_data.stored);
               if (rsp_data.missing_mask !== want.missing_mask)
                  report_mismatch("missing_mask", want.missing_mask, rsp_data.missing_mask);
               if (rsp_data.failsafe !== want.failsafe)
                  report_mismatch("failsafe", want.failsafe, rsp_data.failsafe);
               if (rsp_data.channel_value !== want.channel_value)
                  report_mismatch("channel_value", want.channel_value,
                                  rsp_data.channel_value);
               checked_count++;
            end
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

FILE: sim/tb_ppm_frame_decoder_failsafe_top.sv
`timescale 1ns / 1ps

module tb_ppm_frame_decoder_failsafe_top;

   import ppmfd_pkg::*;

   localparam int                   CYCLE_LIMIT      = 400000;
   localparam int                   TAIL_CYCLES      = 8;
   localparam int                   NUM_PHASES       = 7;
   localparam int                   ITEMS_PER_PHASE  = 215;
   localparam logic [1:0]           KIND_UNUSED      = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   req_type              req_data     = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [TIME_W-1:0]    csr_wdata    = '0;

   int mismatch_count;
   int checked_count;
   int pending_count;
   int cycle_count = 0;

   int send_idle_pct = 35;
   int rsp_stall_pct = 74;
   int kind_count [4];

   // register settings per phase; the last one is drawn at random
   logic [TIME_W-1:0] phase_sync [NUM_PHASES] =
      '{16'd6000, 16'd65535, 16'd3000, 16'd20000, 16'd0, 16'd4000, 16'd0};
   logic [TIME_W-1:0] phase_min [NUM_PHASES] =
      '{16'd1600, 16'd0, 16'd500, 16'd5000, 16'd0, 16'd2500, 16'd0};
   logic [TIME_W-1:0] phase_max [NUM_PHASES] =
      '{16'd4400, 16'd65535, 16'd2500, 16'd4000, 16'd0, 16'd2500, 16'd0};

   logic [TIME_W-1:0] cfg_sync = RST_SYNC_THRESHOLD;
   logic [TIME_W-1:0] cfg_min  = RST_MIN_WIDTH;
   logic [TIME_W-1:0] cfg_max  = RST_MAX_WIDTH;
   logic [TIME_W-1:0] last_t   = '0;

   ppm_frame_decoder_failsafe_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   ppmfd_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (mismatch_count),
      .checked_count (checked_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transactions outstanding",
                  cycle_count, pending_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_type mk_req(input logic [1:0] k, input logic [TIME_W-1:0] t,
                                      input logic [RDCH_W-1:0] ch);
      req_type r;
      r.kind         = k;
      r.edge_time    = t;
      r.read_channel = ch;
      return r;
   endfunction

   // interval that should land inside the width window, when one exists
   function automatic int unsigned channel_gap();
      int unsigned lo;
      int unsigned hi;
      lo = (cfg_min == 0) ? 1 : cfg_min;
      hi = (cfg_max < cfg_sync) ? cfg_max : cfg_sync;
      if (lo <= hi) return $urandom_range(hi, lo);
      return $urandom_range(65536, 1);
   endfunction

   function automatic int unsigned sync_gap();
      return $urandom_range(65536, 32'(cfg_sync) + 1);
   endfunction

   task automatic send_item(input req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      kind_count[rq.kind]++;
   endtask

   task automatic send_edge(input logic [TIME_W-1:0] t);
      last_t = t;
      send_item(mk_req(KIND_EDGE, t, RDCH_W'($urandom)));
   endtask

   // a gap of 65536 gives the same stamp again
   task automatic send_edge_gap(input int unsigned gap);
      send_edge(16'(32'(last_t) + gap));
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic apply_config(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] mn,
                               input logic [TIME_W-1:0] mx);
      cfg_sync = s;
      cfg_min  = mn;
      cfg_max  = mx;
      csr_write_en <= 1'b1;
      csr_index    <= CSR_UNUSED_INDEX;
      csr_wdata    <= 16'($urandom);
      @(posedge clock);
      csr_index <= CSR_SYNC_THRESHOLD;
      csr_wdata <= s;
      @(posedge clock);
      csr_index <= CSR_MIN_WIDTH;
      csr_wdata <= mn;
      @(posedge clock);
      csr_index <= CSR_MAX_WIDTH;
      csr_wdata <= mx;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_random(input int n);
      int sent;
      int pick;
      int nch;
      int k;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            // sync gap, then a run of channel pulses, sometimes past the channel count
            send_edge_gap(sync_gap());
            sent++;
            nch = $urandom_range(NUM_CHANNELS + 2, 1);
            for (k = 0; k < nch; k++) begin
               if ($urandom_range(9) == 0) send_edge_gap($urandom_range(65536, 1));
               else send_edge_gap(channel_gap());
               sent++;
               if ($urandom_range(19) == 0) begin
                  send_item(mk_req(KIND_READ, TIME_W'($urandom), RDCH_W'($urandom)));
                  sent++;
               end
            end
            if ($urandom_range(9) < 6) begin
               send_item(mk_req(KIND_CHECK, TIME_W'($urandom), RDCH_W'($urandom)));
               sent++;
            end
         end else if (pick < 80) begin
            send_item(mk_req(KIND_CHECK, TIME_W'($urandom), RDCH_W'($urandom)));
            sent++;
         end else if (pick < 90) begin
            send_item(mk_req(KIND_READ, TIME_W'($urandom), RDCH_W'($urandom)));
            sent++;
         end else if (pick < 96) begin
            send_edge(TIME_W'($urandom));
            sent++;
         end else begin
            send_item(mk_req(KIND_UNUSED, TIME_W'($urandom), RDCH_W'($urandom)));
            sent++;
         end
         if ($urandom_range(199) == 0) drain_responses();
      end
   endtask

   initial begin
      phase_sync[NUM_PHASES-1] = TIME_W'($urandom);
      phase_min[NUM_PHASES-1]  = TIME_W'($urandom);
      phase_max[NUM_PHASES-1]  = TIME_W'($urandom);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, empty check, window edges, wrap and index saturation
      send_item(mk_req(KIND_READ, TIME_W'($urandom), 4'd1));
      send_item(mk_req(KIND_CHECK, TIME_W'($urandom), RDCH_W'($urandom)));
      send_edge(16'd0);
      send_edge(16'd1600);
      send_edge(16'd6000);
      send_edge(16'd10401);
      send_edge(16'd12000);
      send_edge(16'd18000);
      send_edge(16'hFFFF);
      for (int i = 0; i < 10; i++) send_edge(16'(1999 + i * 2000));
      send_item(mk_req(KIND_CHECK, TIME_W'($urandom), RDCH_W'($urandom)));
      send_item(mk_req(KIND_READ, TIME_W'($urandom), 4'd8));
      send_item(mk_req(KIND_READ, TIME_W'($urandom), 4'd15));
      send_item(mk_req(KIND_UNUSED, TIME_W'($urandom), RDCH_W'($urandom)));
      send_item(mk_req(KIND_READ, TIME_W'($urandom), 4'd0));

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_responses();
         if (phase < 2) begin
            send_idle_pct = 35;
            rsp_stall_pct = 74;
         end else if (phase < 4) begin
            send_idle_pct = 74;
            rsp_stall_pct = 35;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         apply_config(phase_sync[phase], phase_min[phase], phase_max[phase]);
         run_random(ITEMS_PER_PHASE);
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("drove %0d edges, %0d checks, %0d reads, %0d unused-kind items over %0d settings",
               kind_count[KIND_EDGE], kind_count[KIND_CHECK], kind_count[KIND_READ],
               kind_count[KIND_UNUSED], NUM_PHASES + 1);
      $display("compared %0d responses, %0d mismatches", checked_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/ppmfd_pkg.sv
design/ppmfd_chan_mem.sv
design/ppmfd_frame.sv
design/ppm_frame_decoder_failsafe_top.sv
sim/ppmfd_checker.sv
sim/tb_ppm_frame_decoder_failsafe_top.sv
